/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, held off while arst_n is low.
`define CHK_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Check that a trigger is followed by a consequence in the next cycle.
`define CHK_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/gdda_pkg.sv */
// ---------------------------------------------------------------------------
// gdda_pkg
// Types and calendar constants for the Gregorian date day adder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdda_pkg;

	localparam logic [13:0] YEAR_MAX    = 14'd9999;
	localparam logic [13:0] RESET_YEAR  = 14'd2024;
	localparam logic [3:0]  RESET_MONTH = 4'd7;
	localparam logic [4:0]  RESET_DAY   = 5'd12;
	// 2024: 24 into its century, century 20 which is 0 mod 4
	localparam logic [6:0]  RESET_MOD100 = 7'd24;
	localparam logic [1:0]  RESET_CENT4  = 2'd0;

	localparam logic [6:0]  CENTURY     = 7'd100;
	localparam logic [3:0]  DECEMBER    = 4'd12;
	localparam logic [3:0]  FEBRUARY    = 4'd2;
	localparam logic [3:0]  JANUARY     = 4'd1;
	localparam logic [4:0]  FEB_LEAP    = 5'd29;
	localparam logic [4:0]  LONG_MONTH  = 5'd31;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_ADD  = 1'b1;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REDUCE = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	// What the leap rule needs to know about the current year
	typedef struct packed {
		logic [1:0] year_lo;
		logic [6:0] mod100;
		logic [1:0] cent4;
	} leap_info_t;

endpackage

/* sv/gregorian_date_day_adder_unit.sv */
// ---------------------------------------------------------------------------
// gregorian_date_day_adder_unit
// Holds a Gregorian date; loads it or advances it by a day count.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   in      | to block  | in_valid/in_stall  | kind, load_year, load_month, load_day,
//           |           |                    | day_count
//   out     | from block| out_valid/out_stall| cur_year, cur_month, cur_day,
//           |           |                    | year_overflow
//
// Operation: one item at a time. A load item spends its time in the divide-by-100
//   loop that seeds the leap tracking, peeling one century per step. An add item
//   walks one month per step through the shared subtractor until the count lands
//   inside a month or the year saturates.
// Reset: arst_n low sets the date to 2024-07-12 and empties the output.
// Stalls: a finished result waits in the finish state while out_stall holds
//   a previous item in the output register; in_stall is high whenever busy.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gregorian_date_day_adder_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [13:0] load_year,
	input  logic [3:0]  load_month,
	input  logic [4:0]  load_day,
	input  logic [15:0] day_count,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [13:0] cur_year,
	output logic [3:0]  cur_month,
	output logic [4:0]  cur_day,
	output logic        year_overflow
);

	gdda_pkg::state_t state_q;

	// current date and leap tracking: year mod 100 and century mod 4
	logic [13:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [6:0]  mod100_q;
	logic [1:0]  cent4_q;
	logic        ovf_q;

	// remaining days; can briefly exceed 16 bits after the first month step
	logic [16:0] n_q;
	// working year during the divide-by-100 loop
	logic [13:0] red_q;

	logic        out_valid_q;
	logic [13:0] out_year_q;
	logic [3:0]  out_month_q;
	logic [4:0]  out_day_q;
	logic        out_ovf_q;

	gdda_pkg::leap_info_t leap;
	logic [4:0]           len;

	// shared subtractor: borrow set means minuend < subtrahend
	logic [16:0] sub_a;
	logic [16:0] sub_b;
	logic [17:0] sub_diff;
	logic        sub_borrow;
	logic [16:0] walk_sum;
	logic        out_free;

	assign leap.year_lo = year_q[1:0];
	assign leap.mod100  = mod100_q;
	assign leap.cent4   = cent4_q;

	gdda_month_len u_month_len (
		.month (month_q),
		.leap  (leap),
		.len   (len)
	);

	assign walk_sum = n_q + {12'd0, day_q};

	always_comb begin
		if (state_q == gdda_pkg::ST_REDUCE) begin
			sub_a = {3'd0, red_q};
			sub_b = {10'd0, gdda_pkg::CENTURY};
		end else begin
			// day + n fits the month exactly when it is below len + 1
			sub_a = walk_sum;
			sub_b = {11'd0, {1'b0, len} + 6'd1};
		end
	end

	assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_borrow = sub_diff[17];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != gdda_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gdda_pkg::ST_IDLE;
			year_q      <= gdda_pkg::RESET_YEAR;
			month_q     <= gdda_pkg::RESET_MONTH;
			day_q       <= gdda_pkg::RESET_DAY;
			mod100_q    <= gdda_pkg::RESET_MOD100;
			cent4_q     <= gdda_pkg::RESET_CENT4;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// raise the result when the finish state hands it over, drop it once taken
			if (state_q == gdda_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				gdda_pkg::ST_IDLE: begin
					if (in_valid) begin
						ovf_q <= 1'b0;
						if (kind == gdda_pkg::KIND_ADD) begin
							n_q     <= {1'b0, day_count};
							state_q <= gdda_pkg::ST_WALK;
						end else begin
							year_q  <= load_year;
							month_q <= load_month;
							day_q   <= load_day;
							red_q   <= load_year;
							cent4_q <= 2'd0;
							state_q <= gdda_pkg::ST_REDUCE;
						end
					end
				end

				gdda_pkg::ST_REDUCE: begin
					// peel one century per cycle until under 100
					if (sub_borrow) begin
						mod100_q <= red_q[6:0];
						state_q  <= gdda_pkg::ST_FINISH;
					end else begin
						red_q   <= sub_diff[13:0];
						cent4_q <= cent4_q + 2'd1;
					end
				end

				gdda_pkg::ST_WALK: begin
					if (n_q == 17'd0) begin
						state_q <= gdda_pkg::ST_FINISH;
					end else if (sub_borrow) begin
						// rest of the count lands inside this month
						day_q   <= walk_sum[4:0];
						state_q <= gdda_pkg::ST_FINISH;
					end else begin
						n_q <= sub_diff[16:0];
						if (month_q >= gdda_pkg::DECEMBER) begin
							if (year_q >= gdda_pkg::YEAR_MAX) begin
								// saturate and drop what is left
								year_q  <= gdda_pkg::YEAR_MAX;
								month_q <= gdda_pkg::DECEMBER;
								day_q   <= gdda_pkg::LONG_MONTH;
								ovf_q   <= 1'b1;
								state_q <= gdda_pkg::ST_FINISH;
							end else begin
								year_q  <= year_q + 14'd1;
								month_q <= gdda_pkg::JANUARY;
								day_q   <= 5'd1;
								if (mod100_q == gdda_pkg::CENTURY - 7'd1) begin
									mod100_q <= 7'd0;
									cent4_q  <= cent4_q + 2'd1;
								end else begin
									mod100_q <= mod100_q + 7'd1;
								end
							end
						end else begin
							month_q <= month_q + 4'd1;
							day_q   <= 5'd1;
						end
					end
				end

				gdda_pkg::ST_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= gdda_pkg::ST_IDLE;
					end
				end

				default: begin
					state_q <= gdda_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// result payload; no reset needed
	always_ff @(posedge clk) begin
		if (state_q == gdda_pkg::ST_FINISH && out_free) begin
			out_year_q  <= year_q;
			out_month_q <= month_q;
			out_day_q   <= day_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign cur_year      = out_year_q;
	assign cur_month     = out_month_q;
	assign cur_day       = out_day_q;
	assign year_overflow = out_ovf_q;

endmodule

/* sv/gdda_month_len.sv */
// ---------------------------------------------------------------------------
// gdda_month_len
// Length of the current month from the month code and the leap info.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdda_month_len (
	input  logic [3:0]          month,
	input  gdda_pkg::leap_info_t leap,
	output logic [4:0]          len
);

	logic       is_leap;
	logic [3:0] idx;

	// divisible by 4 and not by 100, or divisible by 400
	assign is_leap = (leap.mod100 != 7'd0) ? (leap.year_lo == 2'd0) : (leap.cent4 == 2'd0);
	assign idx     = month - gdda_pkg::JANUARY;

	always_comb begin
		if (month < gdda_pkg::JANUARY || month > gdda_pkg::DECEMBER) begin
			len = gdda_pkg::LONG_MONTH;
		end else if (month == gdda_pkg::FEBRUARY) begin
			len = is_leap ? gdda_pkg::FEB_LEAP : gdda_pkg::MONTH_LEN[1];
		end else begin
			len = gdda_pkg::MONTH_LEN[idx];
		end
	end

endmodule

/* sv/gdda_checker.sv */
// ---------------------------------------------------------------------------
// gdda_checker
// Port-level checks for the Gregorian date day adder, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gdda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        kind,
	input logic [13:0] load_year,
	input logic [3:0]  load_month,
	input logic [4:0]  load_day,
	input logic [15:0] day_count,
	input logic        out_valid,
	input logic        out_stall,
	input logic [13:0] cur_year,
	input logic [3:0]  cur_month,
	input logic [4:0]  cur_day,
	input logic        year_overflow
);

	logic        in_take;
	logic        last_day;
	logic [23:0] out_payload;

	assign in_take     = in_valid && !in_stall;
	assign last_day    = (cur_year == gdda_pkg::YEAR_MAX) && (cur_month == gdda_pkg::DECEMBER)
		&& (cur_day == gdda_pkg::LONG_MONTH);
	assign out_payload = {cur_year, cur_month, cur_day, year_overflow};

	// a saturated add always shows the last day of year 9999
	`CHK_ASSERT(a_ovf_date, !(out_valid && year_overflow) || last_day)

	// the block goes busy right after it takes an item
	`CHK_ASSERT_NEXT(a_busy_after_take, in_take, in_stall)

	// a new result only appears after the block was busy
	`CHK_ASSERT(a_result_from_work, !$rose(out_valid) || $past(in_stall))

	// a stalled result holds
	`CHK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

endmodule

bind gregorian_date_day_adder_unit gdda_checker u_gdda_checker (.*);
